FILE: rtl/core/tcpf_pkg.sv
// Package for the tile cache tag store with parent fallback.
// Holds field widths, operation codes and the command and result structs.
// No dependencies.
package tcpf_pkg;

  localparam int CacheEntries   = 8;
  localparam int FallbackLevels = 3;
  localparam int CoordW         = 20;
  localparam int ZoomW          = 5;
  localparam int SlotW          = 3;
  localparam int StampW         = 32;
  localparam int OpW            = 3;
  localparam int TagW           = 2 * CoordW + ZoomW;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP      = 3'd0,
    OP_ALLOC       = 3'd1,
    OP_MARK        = 3'd2,
    OP_CLEAR       = 3'd3,
    OP_FRAME_BEGIN = 3'd4,
    OP_FRAME_END   = 3'd5
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ZoomW-1:0]  zoom;
    logic [SlotW-1:0]  idx;
    logic              vis;
    logic [StampW-1:0] redraw;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot;
    logic [ZoomW-1:0] zoom;
  } res_t;

endpackage

FILE: rtl/core/tile_cache_parent_fallback_top.sv
// Tile cache tag store with parent-tile fallback, one word at a time.
// Lookup sweeps every entry through the single read port, allocate sweeps and then writes
// the chosen entry, and all other operations pass straight to the write state; each result
// then waits in the output register. The next word is taken only once the previous
// result has been handed to the output register.
// Reset is asynchronous and active low and clears the entry flags, so no clearing pass.
module tile_cache_parent_fallback_top #(
  parameter int CACHE_ENTRIES = tcpf_pkg::CacheEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tcpf_pkg::OpW-1:0]     operation_i,
  input  logic [tcpf_pkg::CoordW-1:0]  tile_x_i,
  input  logic [tcpf_pkg::CoordW-1:0]  tile_y_i,
  input  logic [tcpf_pkg::ZoomW-1:0]   tile_zoom_i,
  input  logic [tcpf_pkg::SlotW-1:0]   entry_index_i,
  input  logic                         visible_i,
  input  logic [tcpf_pkg::StampW-1:0]  redraw_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [tcpf_pkg::SlotW-1:0]   slot_o,
  output logic [tcpf_pkg::ZoomW-1:0]   found_zoom_o
);

  localparam int IdxW = $clog2(CACHE_ENTRIES);

  // Command word assembled from the input ports.
  tcpf_pkg::cmd_t cmd;
  tcpf_pkg::res_t res;
  logic           res_valid, res_ready;

  // Memory port signals; tag and stamp share the read address.
  logic                          rd_en;
  logic [IdxW-1:0]               rd_addr;
  logic                          tag_we, stamp_we;
  logic [IdxW-1:0]               waddr;
  logic [tcpf_pkg::TagW-1:0]     tag_wdata, tag_rdata;
  logic [tcpf_pkg::StampW-1:0]   stamp_wdata, stamp_rdata;

  // Output register: holds one result word until the consumer takes it.
  logic           out_valid_q;
  tcpf_pkg::res_t out_q;

  assign cmd.op     = tcpf_pkg::op_e'(operation_i);
  assign cmd.x      = tile_x_i;
  assign cmd.y      = tile_y_i;
  assign cmd.zoom   = tile_zoom_i;
  assign cmd.idx    = entry_index_i;
  assign cmd.vis    = visible_i;
  assign cmd.redraw = redraw_index_i;

  // The sequencer may hand over a result when the output register is empty or draining.
  assign res_ready = !out_valid_q || out_ready_i;

  tcpf_seq #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (in_valid_i),
    .cmd_i        (cmd),
    .cmd_ready_o  (in_ready_o),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .tag_we_o     (tag_we),
    .stamp_we_o   (stamp_we),
    .waddr_o      (waddr),
    .tag_wdata_o  (tag_wdata),
    .stamp_wdata_o(stamp_wdata),
    .tag_rdata_i  (tag_rdata),
    .stamp_rdata_i(stamp_rdata)
  );

  // Tag memory holds column, row and zoom level of every entry.
  tcpf_ram #(
    .Width(tcpf_pkg::TagW),
    .Depth(CACHE_ENTRIES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(waddr),
    .wdata_i(tag_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(tag_rdata)
  );

  // Stamp memory holds the last-used stamp; a flag in the sequencer marks stamps that read as zero.
  tcpf_ram #(
    .Width(tcpf_pkg::StampW),
    .Depth(CACHE_ENTRIES)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(waddr),
    .wdata_i(stamp_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(stamp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_q.found;
  assign slot_o       = out_q.slot;
  assign found_zoom_o = out_q.zoom;

endmodule

FILE: rtl/core/tcpf_ram.sv
// Simple dual-port synchronous memory: one write port, one registered read port.
// Depends on nothing; used for the tag and stamp arrays.
module tcpf_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tcpf_seq.sv
// Sequencer of the tile cache: sweeps the tag and stamp memories for lookup and
// allocate, and keeps the valid, shown and zero-stamp flags. Uses tcpf_pkg.
module tcpf_seq #(
  parameter int CACHE_ENTRIES = tcpf_pkg::CacheEntries
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  tcpf_pkg::cmd_t                   cmd_i,
  output logic                             cmd_ready_o,
  output logic                             res_valid_o,
  output tcpf_pkg::res_t                   res_o,
  input  logic                             res_ready_i,
  output logic                             rd_en_o,
  output logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr_o,
  output logic                             tag_we_o,
  output logic                             stamp_we_o,
  output logic [$clog2(CACHE_ENTRIES)-1:0] waddr_o,
  output logic [tcpf_pkg::TagW-1:0]        tag_wdata_o,
  output logic [tcpf_pkg::StampW-1:0]      stamp_wdata_o,
  input  logic [tcpf_pkg::TagW-1:0]        tag_rdata_i,
  input  logic [tcpf_pkg::StampW-1:0]      stamp_rdata_i
);

  localparam int IdxW = $clog2(CACHE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  tcpf_pkg::cmd_t               cmd_q;
  logic [IdxW-1:0]              cnt_q, cnt_d;
  logic                         iss_done_q, iss_done_d;
  logic                         chk_q, chk_d;
  logic [IdxW-1:0]              chk_idx_q, chk_idx_d;
  logic                         best_hit_q, best_hit_d;
  logic [IdxW-1:0]              best_idx_q, best_idx_d;
  logic [tcpf_pkg::ZoomW-1:0]   best_diff_q, best_diff_d;
  logic [tcpf_pkg::ZoomW-1:0]   best_lvl_q, best_lvl_d;
  logic [tcpf_pkg::StampW-1:0]  best_stamp_q, best_stamp_d;
  logic [CACHE_ENTRIES-1:0]     valid_q, valid_d;
  logic [CACHE_ENTRIES-1:0]     shown_q, shown_d;
  logic [CACHE_ENTRIES-1:0]     zero_q, zero_d;

  logic [tcpf_pkg::CoordW-1:0]  tag_col, tag_row, shx, shy;
  logic [tcpf_pkg::ZoomW-1:0]   tag_lvl, diff;
  logic [tcpf_pkg::StampW-1:0]  eff_stamp;
  logic                         lk_hit, al_cand, idx_ok;
  logic [IdxW-1:0]              idx_addr;

  // Entry evaluation for the word read in the previous cycle.
  assign tag_col   = tag_rdata_i[tcpf_pkg::TagW-1 -: tcpf_pkg::CoordW];
  assign tag_row   = tag_rdata_i[tcpf_pkg::ZoomW +: tcpf_pkg::CoordW];
  assign tag_lvl   = tag_rdata_i[tcpf_pkg::ZoomW-1:0];
  assign diff      = cmd_q.zoom - tag_lvl;
  assign shx       = cmd_q.x >> diff;
  assign shy       = cmd_q.y >> diff;
  assign lk_hit    = valid_q[chk_idx_q] && (tag_lvl <= cmd_q.zoom) &&
                     (diff <= tcpf_pkg::ZoomW'(tcpf_pkg::FallbackLevels)) &&
                     (tag_col == shx) && (tag_row == shy);
  assign eff_stamp = zero_q[chk_idx_q] ? '0 : stamp_rdata_i;
  assign al_cand   = !shown_q[chk_idx_q] && (eff_stamp < best_stamp_q);
  assign idx_ok    = int'(cmd_q.idx) < CACHE_ENTRIES;
  assign idx_addr  = IdxW'(cmd_q.idx);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    iss_done_d    = iss_done_q;
    chk_d         = chk_q;
    chk_idx_d     = chk_idx_q;
    best_hit_d    = best_hit_q;
    best_idx_d    = best_idx_q;
    best_diff_d   = best_diff_q;
    best_lvl_d    = best_lvl_q;
    best_stamp_d  = best_stamp_q;
    valid_d       = valid_q;
    shown_d       = shown_q;
    zero_d        = zero_q;
    rd_en_o       = 1'b0;
    rd_addr_o     = cnt_q;
    tag_we_o      = 1'b0;
    stamp_we_o    = 1'b0;
    waddr_o       = best_idx_q;
    tag_wdata_o   = {cmd_q.x, cmd_q.y, cmd_q.zoom};
    stamp_wdata_o = cmd_q.redraw;
    cmd_ready_o   = (state_q == ST_IDLE);
    res_valid_o   = (state_q == ST_DONE);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cnt_d        = '0;
          iss_done_d   = 1'b0;
          chk_d        = 1'b0;
          best_hit_d   = 1'b0;
          best_idx_d   = '0;
          best_diff_d  = '0;
          best_lvl_d   = '0;
          best_stamp_d = '1;
          if ((cmd_i.op == tcpf_pkg::OP_LOOKUP) || (cmd_i.op == tcpf_pkg::OP_ALLOC)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_SCAN: begin
        chk_d = !iss_done_q;
        if (!iss_done_q) begin
          rd_en_o   = 1'b1;
          chk_idx_d = cnt_q;
          if (cnt_q == IdxW'(CACHE_ENTRIES - 1)) begin
            iss_done_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (chk_q) begin
          if (cmd_q.op == tcpf_pkg::OP_LOOKUP) begin
            // Nearest level wins; within a level the lowest index wins.
            if (lk_hit && (!best_hit_q || (diff < best_diff_q))) begin
              best_hit_d  = 1'b1;
              best_idx_d  = chk_idx_q;
              best_diff_d = diff;
              best_lvl_d  = tag_lvl;
            end
          end else if (al_cand) begin
            best_hit_d   = 1'b1;
            best_idx_d   = chk_idx_q;
            best_stamp_d = eff_stamp;
          end
          if (iss_done_q) begin
            state_d = (cmd_q.op == tcpf_pkg::OP_ALLOC) ? ST_WRITE : ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
        unique case (cmd_q.op)
          tcpf_pkg::OP_ALLOC: begin
            if (best_hit_q) begin
              tag_we_o            = 1'b1;
              stamp_we_o          = 1'b1;
              valid_d[best_idx_q] = 1'b1;
              shown_d[best_idx_q] = cmd_q.vis;
              zero_d[best_idx_q]  = !cmd_q.vis;
            end
          end
          tcpf_pkg::OP_MARK: begin
            if (idx_ok) begin
              stamp_we_o        = 1'b1;
              waddr_o           = idx_addr;
              shown_d[idx_addr] = cmd_q.vis;
              zero_d[idx_addr]  = !cmd_q.vis;
            end
          end
          tcpf_pkg::OP_CLEAR: begin
            if (idx_ok) begin
              valid_d[idx_addr] = 1'b0;
              shown_d[idx_addr] = 1'b0;
              zero_d[idx_addr]  = 1'b1;
            end
          end
          tcpf_pkg::OP_FRAME_BEGIN: begin
            shown_d = '0;
          end
          tcpf_pkg::OP_FRAME_END: begin
            zero_d = zero_q | ~shown_q;
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.found = 1'b1;
    res_o.slot  = '0;
    res_o.zoom  = cmd_q.zoom;
    unique case (cmd_q.op)
      tcpf_pkg::OP_LOOKUP: begin
        res_o.found = best_hit_q;
        if (best_hit_q) begin
          res_o.slot = tcpf_pkg::SlotW'(best_idx_q);
          res_o.zoom = best_lvl_q;
        end
      end
      tcpf_pkg::OP_ALLOC: begin
        res_o.found = best_hit_q;
        if (best_hit_q) begin
          res_o.slot = tcpf_pkg::SlotW'(best_idx_q);
        end
      end
      tcpf_pkg::OP_MARK, tcpf_pkg::OP_CLEAR: begin
        res_o.slot = cmd_q.idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      iss_done_q <= 1'b0;
      chk_q      <= 1'b0;
      valid_q    <= '0;
      shown_q    <= '0;
      zero_q     <= '1;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      iss_done_q <= iss_done_d;
      chk_q      <= chk_d;
      valid_q    <= valid_d;
      shown_q    <= shown_d;
      zero_q     <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
    end
    chk_idx_q    <= chk_idx_d;
    best_hit_q   <= best_hit_d;
    best_idx_q   <= best_idx_d;
    best_diff_q  <= best_diff_d;
    best_lvl_q   <= best_lvl_d;
    best_stamp_q <= best_stamp_d;
  end

endmodule

FILE: tb/tcpf_result_monitor.sv
// Result monitor for the tile cache tag store: watches the input and result channels,
// keeps its own copy of the tag store to predict every result, and compares field by field.
// Depends on tcpf_pkg for widths, operation codes and the result struct.
module tcpf_result_monitor
  import tcpf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OpW-1:0]    operation_i,
  input  logic [CoordW-1:0] tile_x_i,
  input  logic [CoordW-1:0] tile_y_i,
  input  logic [ZoomW-1:0]  tile_zoom_i,
  input  logic [SlotW-1:0]  entry_index_i,
  input  logic              visible_i,
  input  logic [StampW-1:0] redraw_index_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              found_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic [ZoomW-1:0]  found_zoom_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  // Shadow copy of the tag store.
  logic [CoordW-1:0] tag_col   [CacheEntries];
  logic [CoordW-1:0] tag_row   [CacheEntries];
  logic [ZoomW-1:0]  tag_zoom  [CacheEntries];
  logic              tag_valid [CacheEntries];
  logic              on_screen [CacheEntries];
  logic [StampW-1:0] last_used [CacheEntries];

  res_t        expected_q[$];
  int unsigned mismatches;
  int unsigned checked;

  function automatic int find_tile(input logic [CoordW-1:0] col,
                                   input logic [CoordW-1:0] row,
                                   input logic [ZoomW-1:0]  zoom);
    for (int i = 0; i < CacheEntries; i++) begin
      if (tag_valid[i] && tag_col[i] == col && tag_row[i] == row && tag_zoom[i] == zoom) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one word to the shadow store and returns the result it must produce.
  function automatic res_t predict_tile(input logic [OpW-1:0]    op,
                                        input logic [CoordW-1:0] x,
                                        input logic [CoordW-1:0] y,
                                        input logic [ZoomW-1:0]  zoom,
                                        input logic [SlotW-1:0]  idx,
                                        input logic              vis,
                                        input logic [StampW-1:0] redraw);
    res_t              r;
    int                hit;
    int                pick;
    int                depth;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by;
    logic [ZoomW-1:0]  bz;
    logic [StampW-1:0] best;
    r.found = 1'b1;
    r.slot  = '0;
    r.zoom  = zoom;
    case (op)
      OP_LOOKUP: begin
        hit   = find_tile(x, y, zoom);
        bx    = x;
        by    = y;
        bz    = zoom;
        depth = 0;
        // Walk up to coarser parents until a hit, zoom zero or the level budget.
        while (hit < 0 && bz != '0 && depth < FallbackLevels) begin
          bz  = bz - 1'b1;
          bx  = bx >> 1;
          by  = by >> 1;
          depth++;
          hit = find_tile(bx, by, bz);
        end
        if (hit >= 0) begin
          r.slot = SlotW'(hit);
          r.zoom = tag_zoom[hit];
        end else begin
          r.found = 1'b0;
        end
      end
      OP_ALLOC: begin
        pick = -1;
        best = '1;
        for (int i = 0; i < CacheEntries; i++) begin
          if (!on_screen[i] && last_used[i] < best) begin
            best = last_used[i];
            pick = i;
          end
        end
        if (pick >= 0) begin
          tag_col[pick]   = x;
          tag_row[pick]   = y;
          tag_zoom[pick]  = zoom;
          tag_valid[pick] = 1'b1;
          on_screen[pick] = vis;
          last_used[pick] = vis ? redraw : '0;
          r.slot          = SlotW'(pick);
        end else begin
          r.found = 1'b0;
        end
      end
      OP_MARK: begin
        r.slot         = idx;
        on_screen[idx] = vis;
        last_used[idx] = vis ? redraw : '0;
      end
      OP_CLEAR: begin
        r.slot         = idx;
        tag_valid[idx] = 1'b0;
        tag_col[idx]   = '0;
        tag_row[idx]   = '0;
        tag_zoom[idx]  = '0;
        on_screen[idx] = 1'b0;
        last_used[idx] = '0;
      end
      OP_FRAME_BEGIN: begin
        for (int i = 0; i < CacheEntries; i++) on_screen[i] = 1'b0;
      end
      OP_FRAME_END: begin
        for (int i = 0; i < CacheEntries; i++) begin
          if (!on_screen[i]) last_used[i] = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CacheEntries; i++) begin
        tag_col[i]   = '0;
        tag_row[i]   = '0;
        tag_zoom[i]  = '0;
        tag_valid[i] = 1'b0;
        on_screen[i] = 1'b0;
        last_used[i] = '0;
      end
      expected_q.delete();
      mismatches       = 0;
      checked          = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      checked_o        <= 0;
    end else begin
      // Results first: a word accepted at this edge cannot have its result out yet.
      if (out_valid_i && out_ready_i) begin
        got = {found_i, slot_i, found_zoom_i};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t monitor: result with nothing expected: found %0b slot %0d zoom %0d",
                     $time, got.found, got.slot, got.zoom);
          end
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got.found !== want.found || got.slot !== want.slot || got.zoom !== want.zoom) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%0t monitor: result %0d expected found %0b slot %0d zoom %0d, got %0b %0d %0d",
                       $time, checked, want.found, want.slot, want.zoom,
                       got.found, got.slot, got.zoom);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.insert(expected_q.size(),
                          predict_tile(operation_i, tile_x_i, tile_y_i, tile_zoom_i,
                                       entry_index_i, visible_i, redraw_index_i));
      end
      mismatch_count_o <= mismatches;
      pending_o        <= expected_q.size();
      checked_o        <= checked;
    end
  end

endmodule

FILE: tb/tile_cache_parent_fallback_top_tb.sv
// Testbench top for the tile cache tag store: drives words into the block with random
// idling on both channels and gives the verdict. Depends on tcpf_pkg, the block and
// tcpf_result_monitor, which predicts and checks every result.
module tile_cache_parent_fallback_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpf_pkg::*;

  // The two operation codes the block leaves unused; they must act as no-ops.
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  // Words to send in total: the directed opening plus the random frames.
  localparam int unsigned TotalWords  = 640;
  // Idle time after the final drain, to cover any straggler.
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RegionTiles = 12;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              out_ready_i    = 1'b0;
  logic [OpW-1:0]    operation_i    = '0;
  logic [CoordW-1:0] tile_x_i       = '0;
  logic [CoordW-1:0] tile_y_i       = '0;
  logic [ZoomW-1:0]  tile_zoom_i    = '0;
  logic [SlotW-1:0]  entry_index_i  = '0;
  logic              visible_i      = 1'b0;
  logic [StampW-1:0] redraw_index_i = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              found_o;
  logic [SlotW-1:0]  slot_o;
  logic [ZoomW-1:0]  found_zoom_o;

  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned checked_words;

  // Stimulus bookkeeping.
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned op_tally[8];
  int unsigned calm_words  = 0;
  int unsigned stall_left  = 0;
  int unsigned steady_left = 0;
  int unsigned frame_no    = 0;

  // Recently allocated tiles, so that lookups come back to them and to their children.
  logic [CoordW-1:0] recent_x[RegionTiles];
  logic [CoordW-1:0] recent_y[RegionTiles];
  logic [ZoomW-1:0]  recent_z[RegionTiles];
  int unsigned       recent_count = 0;
  int unsigned       recent_next  = 0;

  // The area of the map currently on screen.
  logic [CoordW-1:0] view_x;
  logic [CoordW-1:0] view_y;
  logic [ZoomW-1:0]  view_z;

  tile_cache_parent_fallback_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .tile_x_i,
    .tile_y_i,
    .tile_zoom_i,
    .entry_index_i,
    .visible_i,
    .redraw_index_i,
    .out_valid_o,
    .out_ready_i,
    .found_o,
    .slot_o,
    .found_zoom_o
  );

  tcpf_result_monitor u_monitor (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .operation_i,
    .tile_x_i,
    .tile_y_i,
    .tile_zoom_i,
    .entry_index_i,
    .visible_i,
    .redraw_index_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .found_i          (found_o),
    .slot_i           (slot_o),
    .found_zoom_i     (found_zoom_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_words),
    .checked_o        (checked_words)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A hung handshake must not hang the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly the current frame number, sometimes the largest stamp or any value at all.
  function automatic logic [StampW-1:0] stamp_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return frame_no;
    if (r < 90) return '1;
    return $urandom;
  endfunction

  // The result side stalls at random, with stretches of steady readiness in between.
  // The stall state changes only at a rising edge, so the block sees a clean ready.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (steady_left != 0) begin
        steady_left <= steady_left - 1;
      end else if ($urandom_range(99) < 4) begin
        steady_left <= $urandom_range(20, 80);
      end else begin
        stall_left <= idle_len();
      end
    end
  end

  // Presents one word and returns at the edge where it is accepted. Valid stays high
  // from there, so a following word with no gap goes out at the very next edge.
  task automatic send_word(input logic [OpW-1:0]    op,
                           input logic [CoordW-1:0] x,
                           input logic [CoordW-1:0] y,
                           input logic [ZoomW-1:0]  zoom,
                           input logic [SlotW-1:0]  idx,
                           input logic              vis,
                           input logic [StampW-1:0] redraw);
    int unsigned gap;
    gap = (calm_words != 0) ? 0 : idle_len();
    if (calm_words != 0) begin
      calm_words--;
    end else if ($urandom_range(99) < 3) begin
      calm_words = $urandom_range(15, 60);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    tile_x_i       <= x;
    tile_y_i       <= y;
    tile_zoom_i    <= zoom;
    entry_index_i  <= idx;
    visible_i      <= vis;
    redraw_index_i <= redraw;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    op_tally[op]++;
  endtask

  // Fields an operation does not use carry random values; the block must ignore them.
  task automatic lookup_tile(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                             input logic [ZoomW-1:0] zoom);
    send_word(OP_LOOKUP, x, y, zoom, $urandom, $urandom, $urandom);
  endtask

  task automatic alloc_tile(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                            input logic [ZoomW-1:0] zoom, input logic vis,
                            input logic [StampW-1:0] redraw);
    send_word(OP_ALLOC, x, y, zoom, $urandom, vis, redraw);
  endtask

  task automatic mark_entry(input logic [SlotW-1:0] idx, input logic vis,
                            input logic [StampW-1:0] redraw);
    send_word(OP_MARK, $urandom, $urandom, $urandom, idx, vis, redraw);
  endtask

  task automatic plain_op(input logic [OpW-1:0] op, input logic [SlotW-1:0] idx);
    send_word(op, $urandom, $urandom, $urandom, idx, $urandom, $urandom);
  endtask

  // Holds the sender back until every result sent so far has come out. The monitor's
  // count is registered, so by the edge after the last acceptance it already includes it.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  // Opening sequence: all-ones coordinates, zoom beyond the usual range, parent fallback
  // over the full three levels and one level too many, the stop at zoom zero, an allocate
  // that finds every entry either on screen or stamped with the largest value, the end of
  // frame that frees such entries again, hide, clear and the two unused codes.
  task automatic directed_words();
    lookup_tile('0, '0, '0);
    alloc_tile('1, '1, 5'd31, 1'b1, '1);
    lookup_tile('1, '1, 5'd31);
    alloc_tile(20'h01234, 20'h00ABC, 5'd10, 1'b0, $urandom);
    lookup_tile(20'h091A5, 20'h055E2, 5'd13);
    lookup_tile(20'h12349, 20'h0ABC3, 5'd14);
    alloc_tile('0, '0, '0, 1'b1, 32'd5);
    lookup_tile(20'h1, 20'h0, 5'd2);
    lookup_tile(20'h5, 20'h7, 5'd0);
    mark_entry(3'd7, 1'b1, '1);
    plain_op(OP_FRAME_BEGIN, $urandom);
    for (int i = 1; i <= 6; i++) mark_entry(i, 1'b1, $urandom_range(1, 1000));
    alloc_tile($urandom, $urandom, $urandom_range(0, 20), 1'b1, $urandom);
    plain_op(OP_FRAME_END, $urandom);
    alloc_tile(20'h7, 20'h9, 5'd20, 1'b1, 32'd77);
    mark_entry(3'd3, 1'b0, $urandom);
    plain_op(OP_CLEAR, 3'd1);
    lookup_tile('0, '0, '0);
    plain_op(OpSpareLo, $urandom);
    plain_op(OpSpareHi, $urandom);
  endtask

  // One screen redraw: drop the marks, look up a handful of tiles, load some of them,
  // show or hide entries, then, in most frames, age out whatever was not drawn.
  task automatic run_frame();
    int unsigned       n_tiles;
    int unsigned       pick;
    int unsigned       depth;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ZoomW-1:0]  zoom;
    frame_no++;
    plain_op(OP_FRAME_BEGIN, $urandom);
    n_tiles = $urandom_range(2, 8);
    for (int k = 0; k < n_tiles; k++) begin
      if (recent_count != 0 && $urandom_range(99) < 65) begin
        // A known tile or one of its children up to one level past the fallback reach.
        pick  = $urandom_range(recent_count - 1);
        depth = $urandom_range(0, FallbackLevels + 1);
        if (int'(recent_z[pick]) + depth > 31) depth = 0;
        x    = (recent_x[pick] << depth) | CoordW'($urandom_range((1 << depth) - 1));
        y    = (recent_y[pick] << depth) | CoordW'($urandom_range((1 << depth) - 1));
        zoom = recent_z[pick] + ZoomW'(depth);
      end else begin
        x    = view_x + CoordW'($urandom_range(7));
        y    = view_y + CoordW'($urandom_range(7));
        zoom = view_z;
      end
      lookup_tile(x, y, zoom);
      if ($urandom_range(99) < 55) begin
        alloc_tile(x, y, zoom, $urandom_range(99) < 75, stamp_value());
        recent_x[recent_next] = x;
        recent_y[recent_next] = y;
        recent_z[recent_next] = zoom;
        recent_next           = (recent_next + 1) % RegionTiles;
        if (recent_count < RegionTiles) recent_count++;
      end
      if ($urandom_range(99) < 40) mark_entry($urandom, $urandom_range(99) < 70, stamp_value());
    end
    if ($urandom_range(99) < 85) plain_op(OP_FRAME_END, $urandom);
  endtask

  initial begin
    int unsigned frames;
    frames = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_words();
    // Let the store settle completely once before the random frames start.
    wait_drained();

    while (words_sent < TotalWords) begin
      // Pan to a new area now and then; a few areas sit beyond the usual zoom range.
      if (frames % 12 == 0) begin
        view_x = $urandom;
        view_y = $urandom;
        view_z = ($urandom_range(99) < 90) ? $urandom_range(0, 20) : $urandom_range(21, 31);
      end
      // Stray words with every field random, unused codes included.
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 4)) send_word($urandom, $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom);
      end
      run_frame();
      frames++;
      if (frames % 25 == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d words in %0d frames, %0d results checked, %0d cycles",
             words_sent, frames, checked_words, cycle_count);
    $display("tb: %0d lookups, %0d allocates, %0d show/hide, %0d clears, %0d frame marks",
             op_tally[OP_LOOKUP], op_tally[OP_ALLOC], op_tally[OP_MARK], op_tally[OP_CLEAR],
             op_tally[OP_FRAME_BEGIN] + op_tally[OP_FRAME_END]);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tcpf_pkg.sv
rtl/core/tcpf_ram.sv
rtl/core/tcpf_seq.sv
rtl/core/tile_cache_parent_fallback_top.sv
tb/tcpf_result_monitor.sv
tb/tile_cache_parent_fallback_top_tb.sv
